[design/ffsb_pkg.sv]
// ----------------------------------------------------------------------------
// ffsb_pkg
// Shared constants for the first-fit slot booking block: default sizes and
// the fixed widths of the request and response fields.
// ----------------------------------------------------------------------------
`default_nettype none

package ffsb_pkg;

   localparam int NUM_VEHICLES_DEF = 16;
   localparam int NUM_SLOTS_DEF    = 24;

   localparam int HOUR_W  = 5;   // start_hour / end_hour
   localparam int VIDX_W  = 4;   // vehicle_index
   localparam int INUSE_W = 5;   // vehicles_in_use

   // Width used to compare an hour against a slot position (slots up to 128).
   localparam int CMP_W   = 7;

endpackage : ffsb_pkg

`default_nettype wire

[design/ffsb_ram.sv]
// ----------------------------------------------------------------------------
// ffsb_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule : ffsb_ram

`default_nettype wire

[design/first_fit_slot_booking.sv]
// An empty booking range answers straight from idle, without a scan; otherwise the
// vehicles are read in order from vehicle 0 and the booking answers on the first
// vehicle that fits, or after the last vehicle is checked when it fits nowhere.
// Throughput: one request at a time, set by the scan of one vehicle bitmap per
// cycle through the single read port; the next request can be taken in the cycle after the response.
// Reset (synchronous): all vehicles read as free at once, count returns to zero.
// ----------------------------------------------------------------------------
// first_fit_slot_booking
// Finds the first vehicle whose requested hour slots are all free, marks them
// busy and reports the vehicle and the number of vehicles in use, or that none fits.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_slot_booking
   import ffsb_pkg::*;
#(
   parameter int NUM_VEHICLES = NUM_VEHICLES_DEF,
   parameter int NUM_SLOTS    = NUM_SLOTS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [HOUR_W-1:0]  req_start_hour,
   input  wire logic [HOUR_W-1:0]  req_end_hour,

   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_placed,
   output logic [VIDX_W-1:0]       rsp_vehicle_index,
   output logic [INUSE_W-1:0]      rsp_vehicles_in_use
);

   localparam int VW = (NUM_VEHICLES > 1) ? $clog2(NUM_VEHICLES) : 1;
   localparam int CW = $clog2(NUM_VEHICLES + 1);
   localparam logic [VW-1:0] LAST_VEH = VW'(NUM_VEHICLES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } state_type;

   state_type              state_ff, state_in;
   logic [NUM_SLOTS-1:0]   mask_ff, mask_in;
   logic [VW-1:0]          scan_addr_ff, scan_addr_in;
   logic                   issue_ff, issue_in;
   logic                   chk_ff, chk_in;
   logic [VW-1:0]          chk_idx_ff, chk_idx_in;
   logic [NUM_VEHICLES-1:0] valid_ff, valid_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   placed_ff, placed_in;
   logic [VW-1:0]          vidx_ff, vidx_in;

   logic [NUM_SLOTS-1:0]   req_mask;
   logic [CMP_W-1:0]       start_ext;
   logic [CMP_W-1:0]       end_ext;
   logic [NUM_SLOTS-1:0]   rd_data;
   logic [NUM_SLOTS-1:0]   chk_entry;
   logic                   wr_en;
   logic                   rd_en;
   logic [VW+VIDX_W-1:0]   vidx_wide;
   logic [CW+INUSE_W-1:0]  count_wide;

   // Slots past the day never enter the mask, which clamps end_hour.
   assign start_ext = CMP_W'(req_start_hour);
   assign end_ext   = CMP_W'(req_end_hour);

   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         req_mask[i] = (start_ext <= CMP_W'(i)) && (CMP_W'(i) < end_ext);
      end
   end

   ffsb_ram #(
      .WIDTH (NUM_SLOTS),
      .DEPTH (NUM_VEHICLES)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (chk_idx_ff),
      .wr_data (chk_entry | mask_ff),
      .rd_en   (rd_en),
      .rd_addr (scan_addr_ff),
      .rd_data (rd_data)
   );

   // An entry never written since reset is a free vehicle.
   assign chk_entry = valid_ff[chk_idx_ff] ? rd_data : '0;
   assign rd_en     = (state_ff == ST_SCAN) && issue_ff;
   assign wr_en     = (state_ff == ST_SCAN) && chk_ff && ((chk_entry & mask_ff) == '0);

   always_comb begin
      state_in     = state_ff;
      mask_in      = mask_ff;
      scan_addr_in = scan_addr_ff;
      issue_in     = issue_ff;
      chk_in       = chk_ff;
      chk_idx_in   = chk_idx_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      placed_in    = placed_ff;
      vidx_in      = vidx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mask_in      = req_mask;
               scan_addr_in = '0;
               chk_in       = 1'b0;
               if (req_mask == '0) begin
                  // empty range: lands on vehicle 0, nothing changes
                  placed_in = 1'b1;
                  vidx_in   = '0;
                  issue_in  = 1'b0;
                  state_in  = ST_RESP;
               end else begin
                  issue_in  = 1'b1;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // advance read address while checking the previous read
            chk_in     = issue_ff;
            chk_idx_in = scan_addr_ff;
            if (issue_ff) begin
               if (scan_addr_ff == LAST_VEH) begin
                  issue_in = 1'b0;
               end else begin
                  scan_addr_in = scan_addr_ff + VW'(1);
               end
            end
            if (chk_ff) begin
               if (wr_en) begin
                  valid_in[chk_idx_ff] = 1'b1;
                  placed_in = 1'b1;
                  vidx_in   = chk_idx_ff;
                  // used vehicles form a prefix: a hit on the first free one grows it
                  if (CW'(chk_idx_ff) == count_ff) begin
                     count_in = count_ff + CW'(1);
                  end
                  issue_in = 1'b0;
                  chk_in   = 1'b0;
                  state_in = ST_RESP;
               end else if (chk_idx_ff == LAST_VEH) begin
                  placed_in = 1'b0;
                  vidx_in   = '0;
                  issue_in  = 1'b0;
                  chk_in    = 1'b0;
                  state_in  = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         issue_ff <= 1'b0;
         chk_ff   <= 1'b0;
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
         chk_ff   <= chk_in;
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
      mask_ff      <= mask_in;
      scan_addr_ff <= scan_addr_in;
      chk_idx_ff   <= chk_idx_in;
      placed_ff    <= placed_in;
      vidx_ff      <= vidx_in;
   end

   assign vidx_wide  = {{VIDX_W{1'b0}}, vidx_ff};
   assign count_wide = {{INUSE_W{1'b0}}, count_ff};

   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = (state_ff == ST_RESP);
   assign rsp_placed          = placed_ff;
   assign rsp_vehicle_index   = vidx_wide[VIDX_W-1:0];
   assign rsp_vehicles_in_use = count_wide[INUSE_W-1:0];

endmodule : first_fit_slot_booking

`default_nettype wire

[bench/first_fit_slot_booking_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_slot_booking_tb
// Drives booking requests into the first-fit slot booking block and checks
// every response against a bit-level predictor of the vehicle slot maps.
// Directed requests cover empty and out-of-day ranges, full-day bookings and
// a day slot taken on every vehicle. Random requests then fill the fleet. Both
// handshakes idle in random bursts, except in part of the random requests.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_slot_booking_tb;
   import ffsb_pkg::*;

   localparam int VEHICLES = NUM_VEHICLES_DEF;
   localparam int SLOTS    = NUM_SLOTS_DEF;

   typedef struct packed {
      logic [HOUR_W-1:0]  start_hour;
      logic [HOUR_W-1:0]  end_hour;
      logic               placed;
      logic [VIDX_W-1:0]  vehicle_index;
      logic [INUSE_W-1:0] vehicles_in_use;
   } booking_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [HOUR_W-1:0]   req_start_hour = '0;
   logic [HOUR_W-1:0]   req_end_hour = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_placed;
   logic [VIDX_W-1:0]   rsp_vehicle_index;
   logic [INUSE_W-1:0]  rsp_vehicles_in_use;

   logic [SLOTS-1:0]    vehicle_slots [VEHICLES];
   booking_result_type  pending_bookings [$];
   booking_result_type  oldest;
   int                  error_count = 0;
   int                  booked_count = 0;
   int                  empty_count = 0;
   int                  rejected_count = 0;
   int                  response_count = 0;
   int                  stall_left = 0;
   bit                  idle_on = 1'b1;

   first_fit_slot_booking uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_start_hour      (req_start_hour),
      .req_end_hour        (req_end_hour),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_placed          (rsp_placed),
      .rsp_vehicle_index   (rsp_vehicle_index),
      .rsp_vehicles_in_use (rsp_vehicles_in_use)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // First fit over the fleet; updates the slot maps as the block does.
   function automatic booking_result_type book_first_fit(input logic [HOUR_W-1:0] s,
                                                          input logic [HOUR_W-1:0] e);
      booking_result_type r;
      logic [SLOTS-1:0] mask;
      int               hi;
      int               b;
      int               v;
      int               n;
      bit               found;
      bit               gap_seen;
      r = '0;
      r.start_hour = s;
      r.end_hour   = e;
      hi = (e > SLOTS) ? SLOTS : e;
      mask = '0;
      for (b = 0; b < SLOTS; b++)
         if (b >= s && b < hi) mask[b] = 1'b1;
      found = 1'b0;
      for (v = 0; v < VEHICLES; v++) begin
         if (!found && (vehicle_slots[v] & mask) == '0) begin
            vehicle_slots[v] = vehicle_slots[v] | mask;
            r.placed = 1'b1;
            r.vehicle_index = v[VIDX_W-1:0];
            found = 1'b1;
         end
      end
      // count used vehicles up to the first free one
      n = 0;
      gap_seen = 1'b0;
      for (v = 0; v < VEHICLES; v++) begin
         if (vehicle_slots[v] == '0) gap_seen = 1'b1;
         else if (!gap_seen) n++;
      end
      r.vehicles_in_use = n[INUSE_W-1:0];
      if (mask == '0) empty_count++;
      else if (found) booked_count++;
      else rejected_count++;
      return r;
   endfunction

   task automatic send_booking(input logic [HOUR_W-1:0] s, input logic [HOUR_W-1:0] e);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_start_hour <= s;
      req_end_hour   <= e;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_bookings.push_back(book_first_fit(s, e));
   endtask

   task automatic send_random_booking();
      logic [HOUR_W-1:0] s;
      logic [HOUR_W-1:0] e;
      int                pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         // empty range, start anywhere in the field
         s = HOUR_W'($urandom_range(0, 31));
         e = HOUR_W'($urandom_range(0, s));
      end else if (pick < 14) begin
         s = HOUR_W'($urandom_range(0, 31));
         e = HOUR_W'($urandom_range(0, 31));
      end else begin
         s = HOUR_W'($urandom_range(0, SLOTS - 1));
         e = HOUR_W'(s + $urandom_range(1, 3));
      end
      send_booking(s, e);
   endtask

   task automatic test_empty_ranges();
      send_booking(5'd0, 5'd0);
      send_booking(5'd7, 5'd3);
      send_booking(5'd24, 5'd31);
      send_booking(5'd31, 5'd0);
      send_booking(5'd31, 5'd31);
   endtask

   task automatic test_full_day_booking();
      send_booking(5'd0, 5'd1);
      send_booking(5'd0, 5'd24);
   endtask

   task automatic test_last_slot_exhaustion();
      int i;
      // take the last slot on every vehicle but the full one
      for (i = 0; i < VEHICLES - 1; i++) send_booking(5'd23, 5'd24);
      send_booking(5'd23, 5'd31);
      send_booking(5'd16, 5'd24);
      send_booking(5'd22, 5'd23);
   endtask

   task automatic test_random_bookings(input int count);
      int i;
      for (i = 0; i < count; i++) begin
         idle_on = (i % 100) < 80;
         send_random_booking();
      end
   endtask

   task automatic test_random_no_idle(input int count);
      int i;
      idle_on = 1'b0;
      for (i = 0; i < count; i++) send_random_booking();
      req_valid <= 1'b0;
   endtask

   // Check each response and pace the response side.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         response_count++;
         if (pending_bookings.size() == 0) begin
            $display("%0t: response with no request pending: placed %0d vehicle %0d in use %0d",
                     $time, rsp_placed, rsp_vehicle_index, rsp_vehicles_in_use);
            error_count++;
         end else begin
            oldest = pending_bookings.pop_front();
            if (rsp_placed !== oldest.placed) begin
               $display("%0t: booking %0d..%0d placed expected %0d, got %0d", $time,
                        oldest.start_hour, oldest.end_hour, oldest.placed, rsp_placed);
               error_count++;
            end
            if (rsp_vehicle_index !== oldest.vehicle_index) begin
               $display("%0t: booking %0d..%0d vehicle_index expected %0d, got %0d", $time,
                        oldest.start_hour, oldest.end_hour, oldest.vehicle_index,
                        rsp_vehicle_index);
               error_count++;
            end
            if (rsp_vehicles_in_use !== oldest.vehicles_in_use) begin
               $display("%0t: booking %0d..%0d vehicles_in_use expected %0d, got %0d", $time,
                        oldest.start_hour, oldest.end_hour, oldest.vehicles_in_use,
                        rsp_vehicles_in_use);
               error_count++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 10) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      int v;
      for (v = 0; v < VEHICLES; v++) vehicle_slots[v] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_ranges();
      test_full_day_booking();
      test_last_slot_exhaustion();
      test_random_bookings(650);
      test_random_no_idle(180);
      while (pending_bookings.size() != 0) @(posedge clock);
      repeat (VEHICLES + 4) @(posedge clock);
      $display("covered %0d responses: %0d booked, %0d empty ranges, %0d rejected",
               response_count, booked_count, empty_count, rejected_count);
      $display("final fleet use: %0d vehicles, %0d check errors",
               oldest.vehicles_in_use, error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #3_200_000;
      $display("timeout with %0d requests still pending", pending_bookings.size());
      $display("status: fail");
      $finish;
   end

endmodule : first_fit_slot_booking_tb

`default_nettype wire
